/* rtl/decimal_and_identifier_lexer_assert.svh */
// Assertion macros for the decimal and identifier lexer checker.
// Expects clk_i and rst_ni in the scope of the use.
`ifndef DECIMAL_AND_IDENTIFIER_LEXER_ASSERT_SVH
`define DECIMAL_AND_IDENTIFIER_LEXER_ASSERT_SVH

// Same-cycle implication.
`define DILEX_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DILEX_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/dilex_pkg.sv */
// Shared types, constants and character class helpers for the lexer.
// No dependencies.
`timescale 1ns / 1ps

package dilex_pkg;

  localparam int MANTISSA_BITS_DEF = 32;
  localparam int POSITION_BITS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF   = 4;

  localparam int OUT_DATA_W = 80;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_EOB   = 8'h00;

  typedef enum logic [2:0] {
    KIND_ERR  = 3'd0,
    KIND_NUM  = 3'd1,
    KIND_ID   = 3'd2,
    KIND_STAR = 3'd3,
    KIND_PLUS = 3'd4,
    KIND_END  = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_INT  = 3'd1,
    PH_DOT  = 3'd2,
    PH_FRAC = 3'd3,
    PH_ID   = 3'd4
  } phase_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] line;
    logic [15:0] start;
    logic [7:0]  len;
    logic [31:0] mant;
    logic [3:0]  frac;
  } token_t;

  // One lexer step: one or two tokens.
  typedef struct packed {
    logic   two;
    token_t tok0;
    token_t tok1;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } push_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_lower(input logic [7:0] c);
    return (c >= 8'h61) && (c <= 8'h7a);
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5a);
  endfunction

endpackage

/* rtl/dilex_front.sv */
// Scanner front end: takes one byte, steps the token DFA, builds the
// result tokens of that byte. Depends on dilex_pkg.
`timescale 1ns / 1ps

module dilex_front #(
  parameter int MANTISSA_BITS = dilex_pkg::MANTISSA_BITS_DEF,
  parameter int POSITION_BITS = dilex_pkg::POSITION_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             byte_valid_i,
  input  logic [7:0]       byte_i,
  output logic             byte_ready_o,
  input  logic             full_i,
  output dilex_pkg::push_t push_o
);
  import dilex_pkg::*;

  localparam int MW = MANTISSA_BITS;
  localparam int PW = POSITION_BITS;

  phase_e        phase_q, phase_d;
  logic [PW-1:0] line_q, line_d;
  logic [PW-1:0] off_q, off_d;
  logic [PW-1:0] start_q, start_d;
  logic [7:0]    len_q, len_d;
  logic [MW-1:0] mant_q, mant_d;
  logic [3:0]    frac_q, frac_d;

  logic          accept;
  logic [MW+3:0] mant_ext;
  logic [MW-1:0] mant_next;
  logic [7:0]    len_grow;
  logic          restart;
  logic          end_seen;
  logic          e0_vld, f_vld;
  token_t        e0_tok, f_tok;
  logic [3:0]    dig;

  assign byte_ready_o = !full_i;
  assign accept       = byte_valid_i && !full_i;
  assign dig          = byte_i[3:0];

  // mant*10 + d, saturating when it no longer fits
  always_comb begin
    mant_ext  = {1'b0, mant_q, 3'b000} + {3'b000, mant_q, 1'b0} + (MW+4)'(dig);
    mant_next = (mant_ext[MW+3:MW] != 4'd0) ? {MW{1'b1}} : mant_ext[MW-1:0];
    len_grow  = (len_q == 8'hff) ? len_q : len_q + 8'd1;
  end

  always_comb begin
    phase_d  = phase_q;
    line_d   = line_q;
    off_d    = off_q + PW'(1);
    start_d  = start_q;
    len_d    = len_q;
    mant_d   = mant_q;
    frac_d   = frac_q;
    restart  = 1'b0;
    end_seen = 1'b0;
    e0_vld   = 1'b0;
    f_vld    = 1'b0;

    e0_tok       = '0;
    e0_tok.kind  = KIND_ERR;
    e0_tok.line  = 16'(line_q);
    e0_tok.start = 16'(start_q);
    e0_tok.len   = len_q;

    f_tok       = '0;
    f_tok.kind  = KIND_ERR;
    f_tok.line  = 16'(line_q);
    f_tok.start = 16'(off_q);
    f_tok.len   = 8'd1;

    unique case (phase_q)
      PH_INT: begin
        if (is_digit(byte_i)) begin
          mant_d = mant_next;
          len_d  = len_grow;
        end else if (byte_i == CH_DOT) begin
          len_d   = len_grow;
          phase_d = PH_DOT;
        end else begin
          e0_vld  = 1'b1;
          restart = 1'b1;
        end
      end
      PH_DOT: begin
        if (is_digit(byte_i)) begin
          mant_d  = mant_next;
          len_d   = len_grow;
          frac_d  = 4'd1;
          phase_d = PH_FRAC;
        end else begin
          e0_vld  = 1'b1;
          restart = 1'b1;
        end
      end
      PH_FRAC: begin
        if (is_digit(byte_i)) begin
          mant_d = mant_next;
          len_d  = len_grow;
          frac_d = (frac_q == 4'hf) ? frac_q : frac_q + 4'd1;
        end else if (is_lower(byte_i) || is_upper(byte_i)) begin
          e0_vld  = 1'b1;
          restart = 1'b1;
        end else begin
          e0_vld      = 1'b1;
          e0_tok.kind = KIND_NUM;
          e0_tok.mant = 32'(mant_q);
          e0_tok.frac = frac_q;
          restart     = 1'b1;
        end
      end
      PH_ID: begin
        if (is_lower(byte_i) || is_digit(byte_i)) begin
          len_d = len_grow;
        end else if (is_upper(byte_i)) begin
          e0_vld  = 1'b1;
          restart = 1'b1;
        end else begin
          e0_vld      = 1'b1;
          e0_tok.kind = KIND_ID;
          restart     = 1'b1;
        end
      end
      default: begin
        restart = 1'b1;
      end
    endcase

    // the byte opens a fresh token
    if (restart) begin
      phase_d = PH_IDLE;
      if (byte_i == CH_SPACE) begin
        f_vld = 1'b0;
      end else if (byte_i == CH_NL) begin
        if (line_q != {PW{1'b1}}) begin
          line_d = line_q + PW'(1);
        end
      end else if (byte_i == CH_EOB) begin
        f_vld      = 1'b1;
        f_tok.kind = KIND_END;
        f_tok.len  = 8'd0;
        end_seen   = 1'b1;
      end else if (is_digit(byte_i)) begin
        phase_d = PH_INT;
        start_d = off_q;
        len_d   = 8'd1;
        mant_d  = MW'(dig);
        frac_d  = 4'd0;
      end else if (is_lower(byte_i)) begin
        phase_d = PH_ID;
        start_d = off_q;
        len_d   = 8'd1;
        mant_d  = '0;
        frac_d  = 4'd0;
      end else if (byte_i == CH_STAR) begin
        f_vld      = 1'b1;
        f_tok.kind = KIND_STAR;
      end else if (byte_i == CH_PLUS) begin
        f_vld      = 1'b1;
        f_tok.kind = KIND_PLUS;
      end else begin
        f_vld = 1'b1;
      end
    end

    if (end_seen) begin
      line_d  = '0;
      off_d   = '0;
      start_d = '0;
      phase_d = PH_IDLE;
    end
  end

  always_comb begin
    push_o            = '0;
    push_o.valid      = accept && (e0_vld || f_vld);
    push_o.entry.two  = e0_vld && f_vld;
    push_o.entry.tok0 = e0_vld ? e0_tok : f_tok;
    push_o.entry.tok1 = f_tok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      line_q  <= '0;
      off_q   <= '0;
      start_q <= '0;
      len_q   <= '0;
      mant_q  <= '0;
      frac_q  <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      line_q  <= line_d;
      off_q   <= off_d;
      start_q <= start_d;
      len_q   <= len_d;
      mant_q  <= mant_d;
      frac_q  <= frac_d;
    end
  end

endmodule

/* rtl/dilex_fifo.sv */
// Short queue of scanner steps between the front end and the emitter.
// Depends on dilex_pkg.
`timescale 1ns / 1ps

module dilex_fifo #(
  parameter int QUEUE_DEPTH = dilex_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dilex_pkg::push_t  push_i,
  output logic              full_o,
  output logic              head_valid_o,
  output dilex_pkg::entry_t head_o,
  input  logic              pop_i
);
  import dilex_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  entry_t             store_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               do_push, do_pop;

  assign full_o       = (count_q == CNT_W'(QUEUE_DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = store_q[rd_ptr_q];
  assign do_push      = push_i.valid && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_d = count_q + CNT_W'(1);
      2'b01:   count_d = count_q - CNT_W'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= push_i.entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

/* rtl/dilex_back.sv */
// Emitter: unpacks queued steps into single tokens held in the output
// register of the result stream. Depends on dilex_pkg.
`timescale 1ns / 1ps

module dilex_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               head_valid_i,
  input  dilex_pkg::entry_t                  head_i,
  output logic                               pop_o,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [dilex_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic [2:0]                         m_axis_tuser,
  output logic                               m_axis_tlast
);
  import dilex_pkg::*;

  logic                  valid_q;
  logic [OUT_DATA_W-1:0] data_q, data_d;
  logic [2:0]            user_q, user_d;
  logic                  last_q, last_d;
  logic                  idx_q;
  logic                  load;
  token_t                tok;

  always_comb begin
    load   = head_valid_i && (!valid_q || m_axis_tready);
    tok    = idx_q ? head_i.tok1 : head_i.tok0;
    last_d = !head_i.two || idx_q;
    pop_o  = load && last_d;
    data_d = {4'b0000, tok.frac, tok.mant, tok.len, tok.start, tok.line};
    user_d = tok.kind;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
      idx_q   <= !last_d;
    end else if (m_axis_tready) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
      user_q <= user_d;
      last_q <= last_d;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = user_q;
  assign m_axis_tlast  = last_q;

endmodule

/* rtl/decimal_and_identifier_lexer.sv */
// Decimal number and identifier lexer. One source byte is taken per clock
// while the step queue (QUEUE_DEPTH entries) has room; the token DFA and the
// times-ten mantissa update finish in that cycle. Results leave one per cycle,
// while m_axis_tready is high, from an output register; a byte that closes one
// token and is itself a one-byte token yields two results in turn. Byte 0 ends
// the buffer and clears line and offset.
// Top level: instantiates dilex_front, dilex_fifo and dilex_back; uses dilex_pkg.
`timescale 1ns / 1ps

module decimal_and_identifier_lexer #(
  parameter int MANTISSA_BITS = dilex_pkg::MANTISSA_BITS_DEF,
  parameter int POSITION_BITS = dilex_pkg::POSITION_BITS_DEF,
  parameter int QUEUE_DEPTH   = dilex_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // [7:0] source_byte
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [15:0] line_number, [31:16] start_offset, [39:32] token_length,
  // [71:40] number_mantissa, [75:72] fraction_digits
  output logic [dilex_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic [2:0]                       m_axis_tuser,  // [2:0] token_kind
  output logic                             m_axis_tlast   // last_of_run
);
  import dilex_pkg::*;

  push_t  push;
  logic   full;
  logic   head_valid;
  entry_t head;
  logic   pop;

  dilex_front #(
    .MANTISSA_BITS(MANTISSA_BITS),
    .POSITION_BITS(POSITION_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (s_axis_tvalid),
    .byte_i       (s_axis_tdata),
    .byte_ready_o (s_axis_tready),
    .full_i       (full),
    .push_o       (push)
  );

  dilex_fifo #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  dilex_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

/* rtl/dilex_checker.sv */
// Port-level checks on the lexer result stream, bound to the top level.
// Depends on dilex_pkg and decimal_and_identifier_lexer_assert.svh.
`timescale 1ns / 1ps

module dilex_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [dilex_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [2:0]                       m_axis_tuser,
  input logic                             m_axis_tlast
);
  import dilex_pkg::*;
  `include "decimal_and_identifier_lexer_assert.svh"

  logic [2:0]  kind;
  logic [7:0]  len;
  logic [31:0] mant;
  logic [3:0]  frac;
  logic        single;

  assign kind   = m_axis_tuser;
  assign len    = m_axis_tdata[39:32];
  assign mant   = m_axis_tdata[71:40];
  assign frac   = m_axis_tdata[75:72];
  assign single = (kind == KIND_STAR) || (kind == KIND_PLUS) || (kind == KIND_END);

  `DILEX_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast), "result changed while stalled")
  `DILEX_ASSERT_IMP(a_single_last, m_axis_tvalid && single, m_axis_tlast,
    "one-byte or end token not last of its byte")
  `DILEX_ASSERT_IMP(a_end_empty, m_axis_tvalid && (kind == KIND_END),
    (len == 8'd0) && (mant == 32'd0) && (frac == 4'd0), "end token carries payload")
  `DILEX_ASSERT_IMP(a_num_shape, m_axis_tvalid && (kind == KIND_NUM),
    (frac != 4'd0) && (len >= 8'd3), "number token without fraction digits")

endmodule

bind decimal_and_identifier_lexer dilex_checker u_dilex_checker (.*);

/* verif/decimal_and_identifier_lexer_tb.sv */
// Self-checking bench for decimal_and_identifier_lexer: streams source bytes
// in, predicts each token in-bench and compares every output field in order.
// Depends on dilex_pkg and the lexer RTL.
`timescale 1ns / 1ps

module decimal_and_identifier_lexer_tb;
  import dilex_pkg::*;

  localparam logic [7:0] DIGIT_LO = 8'h30;
  localparam logic [7:0] DIGIT_HI = 8'h39;
  localparam logic [7:0] LOWER_LO = 8'h61;
  localparam logic [7:0] LOWER_HI = 8'h7a;
  localparam logic [7:0] UPPER_LO = 8'h41;
  localparam logic [7:0] UPPER_HI = 8'h5a;
  localparam logic [7:0] CH_TOP   = 8'hff;

  typedef struct packed {
    token_t tok;
    logic   last;
  } lex_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata = 8'h00;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [2:0]            m_axis_tuser;
  logic                  m_axis_tlast;

  logic [7:0]  source_bytes[$];
  lex_result_t expected_tokens[$];
  int          mismatch_count = 0;
  int          send_idle_pct  = 15;
  int          recv_stall_pct = 76;

  // scanner state mirrored from the block
  phase_e      scan_ph   = PH_IDLE;
  logic [15:0] line_cnt  = '0;
  logic [15:0] offset    = '0;
  logic [15:0] tok_start = '0;
  logic [7:0]  tok_len   = '0;
  logic [31:0] mant_acc  = '0;
  logic [3:0]  frac_cnt  = '0;

  decimal_and_identifier_lexer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic char_digit(logic [7:0] c);
    return c >= DIGIT_LO && c <= DIGIT_HI;
  endfunction

  function automatic logic char_lower(logic [7:0] c);
    return c >= LOWER_LO && c <= LOWER_HI;
  endfunction

  function automatic logic char_upper(logic [7:0] c);
    return c >= UPPER_LO && c <= UPPER_HI;
  endfunction

  function automatic token_t make_tok(kind_e k, logic [15:0] s, logic [7:0] l,
                                      logic [31:0] m, logic [3:0] f);
    token_t t;
    t.kind  = k;
    t.line  = line_cnt;
    t.start = s;
    t.len   = l;
    t.mant  = m;
    t.frac  = f;
    return t;
  endfunction

  function automatic void bump_len();
    if (tok_len != 8'hff) tok_len++;
  endfunction

  // mantissa saturates instead of wrapping
  function automatic void add_digit(logic [7:0] c);
    logic [35:0] grown;
    grown = {4'd0, mant_acc} * 36'd10 + 36'(c - DIGIT_LO);
    if (grown > 36'hffff_ffff) mant_acc = '1;
    else mant_acc = grown[31:0];
    bump_len();
  endfunction

  function automatic void open_token(phase_e ph);
    scan_ph   = ph;
    tok_start = offset;
    tok_len   = '0;
    mant_acc  = '0;
    frac_cnt  = '0;
  endfunction

  // Advances the scanner by one byte and queues the tokens it closes.
  task automatic scan_byte(logic [7:0] c);
    token_t toks[2];
    int     n;
    logic   restart;
    logic   ended;
    n = 0;
    restart = 1'b0;
    ended = 1'b0;
    case (scan_ph)
      PH_INT: begin
        if (char_digit(c)) begin
          add_digit(c);
        end else if (c == CH_DOT) begin
          bump_len();
          scan_ph = PH_DOT;
        end else begin
          toks[n++] = make_tok(KIND_ERR, tok_start, tok_len, '0, '0);
          restart = 1'b1;
        end
      end
      PH_DOT: begin
        if (char_digit(c)) begin
          add_digit(c);
          frac_cnt = 4'd1;
          scan_ph = PH_FRAC;
        end else begin
          toks[n++] = make_tok(KIND_ERR, tok_start, tok_len, '0, '0);
          restart = 1'b1;
        end
      end
      PH_FRAC: begin
        if (char_digit(c)) begin
          add_digit(c);
          if (frac_cnt != 4'hf) frac_cnt++;
        end else if (char_lower(c) || char_upper(c)) begin
          toks[n++] = make_tok(KIND_ERR, tok_start, tok_len, '0, '0);
          restart = 1'b1;
        end else begin
          toks[n++] = make_tok(KIND_NUM, tok_start, tok_len, mant_acc, frac_cnt);
          restart = 1'b1;
        end
      end
      PH_ID: begin
        if (char_lower(c) || char_digit(c)) begin
          bump_len();
        end else if (char_upper(c)) begin
          toks[n++] = make_tok(KIND_ERR, tok_start, tok_len, '0, '0);
          restart = 1'b1;
        end else begin
          toks[n++] = make_tok(KIND_ID, tok_start, tok_len, '0, '0);
          restart = 1'b1;
        end
      end
      default: restart = 1'b1;
    endcase

    // the terminating byte is scanned again as the start of a new token
    if (restart) begin
      scan_ph = PH_IDLE;
      if (c == CH_SPACE) begin
      end else if (c == CH_NL) begin
        if (line_cnt != 16'hffff) line_cnt++;
      end else if (c == CH_EOB) begin
        toks[n++] = make_tok(KIND_END, offset, 8'd0, '0, '0);
        ended = 1'b1;
      end else if (char_digit(c)) begin
        open_token(PH_INT);
        add_digit(c);
      end else if (char_lower(c)) begin
        open_token(PH_ID);
        bump_len();
      end else if (c == CH_STAR) begin
        toks[n++] = make_tok(KIND_STAR, offset, 8'd1, '0, '0);
      end else if (c == CH_PLUS) begin
        toks[n++] = make_tok(KIND_PLUS, offset, 8'd1, '0, '0);
      end else begin
        toks[n++] = make_tok(KIND_ERR, offset, 8'd1, '0, '0);
      end
    end

    if (ended) begin
      line_cnt  = '0;
      offset    = '0;
      tok_start = '0;
      scan_ph   = PH_IDLE;
    end else begin
      offset++;
    end

    for (int i = 0; i < n; i++) expected_tokens.push_back('{toks[i], i == n - 1});
  endtask

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("MISMATCH %s: got %0d want %0d at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  // Source byte driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (source_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= source_bytes.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Token sink backpressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Predict on accepted bytes, check accepted tokens
  always @(posedge clk_i) begin : token_monitor
    lex_result_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) scan_byte(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_tokens.size() == 0) begin
          report_mismatch("token with none expected, kind", m_axis_tuser, 0);
        end else begin
          want = expected_tokens.pop_front();
          if (m_axis_tuser != want.tok.kind)
            report_mismatch("token_kind", m_axis_tuser, want.tok.kind);
          if (m_axis_tdata[15:0] != want.tok.line)
            report_mismatch("line_number", m_axis_tdata[15:0], want.tok.line);
          if (m_axis_tdata[31:16] != want.tok.start)
            report_mismatch("start_offset", m_axis_tdata[31:16], want.tok.start);
          if (m_axis_tdata[39:32] != want.tok.len)
            report_mismatch("token_length", m_axis_tdata[39:32], want.tok.len);
          if (m_axis_tdata[71:40] != want.tok.mant)
            report_mismatch("number_mantissa", m_axis_tdata[71:40], want.tok.mant);
          if (m_axis_tdata[75:72] != want.tok.frac)
            report_mismatch("fraction_digits", m_axis_tdata[75:72], want.tok.frac);
          if (m_axis_tlast != want.last)
            report_mismatch("last_of_run", m_axis_tlast, want.last);
        end
      end
    end
  end

  function automatic logic [7:0] random_digit();
    return DIGIT_LO + 8'($urandom_range(9));
  endfunction

  function automatic logic [7:0] random_lower();
    return LOWER_LO + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] random_upper();
    return UPPER_LO + 8'($urandom_range(25));
  endfunction

  task automatic push_digits(int lo, int hi);
    repeat ($urandom_range(hi, lo)) source_bytes.push_back(random_digit());
  endtask

  // One random lexeme: mostly well-formed tokens, some malformed ones and noise.
  task automatic push_lexeme();
    int pick;
    pick = $urandom_range(99);
    if (pick < 25) begin
      push_digits(1, 4);
      source_bytes.push_back(CH_DOT);
      push_digits(1, 4);
    end else if (pick < 45) begin
      source_bytes.push_back(random_lower());
      repeat ($urandom_range(5))
        source_bytes.push_back($urandom_range(1) ? random_lower() : random_digit());
    end else if (pick < 53) begin
      source_bytes.push_back($urandom_range(1) ? CH_STAR : CH_PLUS);
    end else if (pick < 65) begin
      source_bytes.push_back($urandom_range(3) == 0 ? CH_NL : CH_SPACE);
    end else if (pick < 68) begin
      source_bytes.push_back(CH_EOB);
    end else if (pick < 76) begin
      push_digits(1, 3);
      case ($urandom_range(2))
        0: source_bytes.push_back($urandom_range(1) ? random_lower() : CH_STAR);
        1: begin
          source_bytes.push_back(CH_DOT);
          source_bytes.push_back($urandom_range(1) ? CH_PLUS : random_lower());
        end
        default: begin
          source_bytes.push_back(CH_DOT);
          push_digits(1, 3);
          source_bytes.push_back($urandom_range(1) ? random_lower() : random_upper());
        end
      endcase
    end else if (pick < 80) begin
      source_bytes.push_back(random_lower());
      push_digits(0, 2);
      source_bytes.push_back(random_upper());
    end else begin
      source_bytes.push_back(8'($urandom_range(255)));
    end
    if ($urandom_range(1)) source_bytes.push_back($urandom_range(3) == 0 ? CH_NL : CH_SPACE);
  endtask

  task automatic push_random(int n_bytes);
    int target;
    target = source_bytes.size() + n_bytes;
    while (source_bytes.size() < target) push_lexeme();
  endtask

  task automatic wait_drained();
    while (source_bytes.size() != 0 || s_axis_tvalid) @(negedge clk_i);
  endtask

  initial begin
    string directed;
    // number, identifier, star, plus, newline, unknown byte, digits without
    // a point, point without digit, fraction then letter, identifier then
    // uppercase, top byte value, end of buffer
    directed = "9.90 az*+\n#1 3. 4.5qbZ";
    for (int i = 0; i < directed.len(); i++) source_bytes.push_back(directed[i]);
    source_bytes.push_back(CH_TOP);
    source_bytes.push_back(CH_EOB);
    push_random(380);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    wait_drained();

    send_idle_pct  = 76;
    recv_stall_pct = 15;
    push_random(380);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    push_random(380);
    // saturation of length, mantissa and fraction count
    repeat (260) source_bytes.push_back(random_lower());
    source_bytes.push_back(CH_SPACE);
    repeat (12) source_bytes.push_back(DIGIT_HI);
    source_bytes.push_back(CH_DOT);
    repeat (20) source_bytes.push_back(random_digit());
    source_bytes.push_back(CH_SPACE);
    source_bytes.push_back(random_lower());
    source_bytes.push_back(CH_SPACE);
    source_bytes.push_back(CH_EOB);
    wait_drained();

    while (expected_tokens.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
